[src/tdpl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the trial-division prime lister.
// No dependencies.
package tdpl_pkg;

  localparam int unsigned ValW     = 9;
  localparam int unsigned PrimeW   = 5;
  // Primes up to the square root of the largest limit: 2, 3, 5, 7, 11, 13, 17.
  localparam int unsigned NumCells = 7;

  localparam logic [ValW-1:0] LimitMax  = 9'd311;
  localparam logic [ValW-1:0] FirstCand = 9'd2;

  typedef struct packed {
    logic            vld;
    logic            fin;
    logic            comp;
    logic            taken;
    logic [ValW-1:0] num;
  } tok_t;

endpackage

[src/tdpl_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one limit per item.
// Depends on tdpl_pkg.
interface tdpl_in_if;
  logic                     valid;
  logic                     ready;
  logic [tdpl_pkg::ValW-1:0] limit;

  modport source (output valid, output limit, input ready);
  modport sink (input valid, input limit, output ready);
endinterface

[src/tdpl_out_if.sv]
`timescale 1ns / 1ps
// Output channel: one prime per item, flagged valid and last.
// Depends on tdpl_pkg.
interface tdpl_out_if;
  logic                     valid;
  logic                     ready;
  logic [tdpl_pkg::ValW-1:0] prime_value;
  logic                     valid_res;
  logic                     last;

  modport source (output valid, output prime_value, output valid_res, output last,
                  input ready);
  modport sink (input valid, input prime_value, input valid_res, input last,
                output ready);
endinterface

[src/trial_division_prime_lister.sv]
`timescale 1ns / 1ps
// Prime lister: candidates 2..min(limit,311) step one per cycle while the output
// does not stall, through a chain of 7 sieve cells, then a closing item; the tail
// emits each prime. Output stalls freeze the whole chain. A new limit is taken only
// after the last result of the previous one has been accepted.
// Reset clears control and empties all cells; no clearing pass is needed.
module trial_division_prime_lister (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdpl_in_if.sink    in_i,
  tdpl_out_if.source out_o
);

  logic                      busy_q, feed_q;
  logic [tdpl_pkg::ValW-1:0] cand_q, lim_q;
  logic                      adv, done, in_take, cand_fin;
  tdpl_pkg::tok_t            tok [tdpl_pkg::NumCells+1];

  assign in_i.ready = !busy_q;
  assign in_take    = in_i.valid && !busy_q;
  assign cand_fin   = cand_q > lim_q;

  always_comb begin
    tok[0].vld   = feed_q;
    tok[0].fin   = cand_fin;
    tok[0].comp  = 1'b0;
    tok[0].taken = 1'b0;
    tok[0].num   = cand_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      feed_q <= 1'b0;
    end else begin
      if (in_take) begin
        busy_q <= 1'b1;
        feed_q <= 1'b1;
      end else begin
        if (done) begin
          busy_q <= 1'b0;
        end
        if (adv && feed_q && cand_fin) begin
          feed_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cand_q <= tdpl_pkg::FirstCand;
      lim_q  <= (in_i.limit > tdpl_pkg::LimitMax) ? tdpl_pkg::LimitMax : in_i.limit;
    end else if (adv && feed_q && !cand_fin) begin
      cand_q <= cand_q + tdpl_pkg::ValW'(1);
    end
  end

  for (genvar i = 0; i < tdpl_pkg::NumCells; i++) begin : g_cell
    tdpl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  tdpl_collect u_collect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok[tdpl_pkg::NumCells]),
    .adv_o  (adv),
    .done_o (done),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_out_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> busy_q)
    else $error("result outside a run");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.valid_res) |-> out_o.last)
    else $error("empty result not last");

  a_cand_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feed_q |-> ((cand_q == tdpl_pkg::FirstCand) ||
                ({1'b0, cand_q} <= ({1'b0, lim_q} + 10'd1))))
    else $error("candidate ran past limit");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (in_i.ready && !feed_q))
    else $error("input not freed after last result");
`endif

endmodule

[src/tdpl_cell.sv]
`timescale 1ns / 1ps
// Sieve cell: holds one small prime and the running residue of the candidate
// stream modulo that prime. Depends on tdpl_pkg.
module tdpl_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  tdpl_pkg::tok_t tok_i,
  output tdpl_pkg::tok_t tok_o
);

  logic                        full_q, full_d;
  logic [tdpl_pkg::PrimeW-1:0] prime_q, prime_d;
  logic [tdpl_pkg::PrimeW-1:0] res_q, res_d, res_inc;
  tdpl_pkg::tok_t              tok_q, tok_d;

  always_comb begin
    tok_d   = tok_i;
    full_d  = full_q;
    prime_d = prime_q;
    res_d   = res_q;
    res_inc = (res_q == (prime_q - tdpl_pkg::PrimeW'(1))) ? '0 :
              (res_q + tdpl_pkg::PrimeW'(1));
    if (tok_i.vld) begin
      if (tok_i.fin) begin
        full_d = 1'b0;
      end else if (full_q) begin
        res_d = res_inc;
        if (res_inc == '0) begin
          tok_d.comp = 1'b1;
        end
      end else if (!tok_i.comp && !tok_i.taken) begin
        full_d      = 1'b1;
        prime_d     = tok_i.num[tdpl_pkg::PrimeW-1:0];
        res_d       = '0;
        tok_d.taken = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      tok_q  <= '0;
    end else if (en_i) begin
      full_q <= full_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prime_q <= prime_d;
      res_q   <= res_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[src/tdpl_collect.sv]
`timescale 1ns / 1ps
// Chain tail: holds back one prime so the final one can carry last, and
// drives the output register. Depends on tdpl_pkg and tdpl_out_if.
module tdpl_collect (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdpl_pkg::tok_t    tok_i,
  output logic              adv_o,
  output logic              done_o,
  tdpl_out_if.source        out_o
);

  logic                      pend_vld_q, pend_vld_d;
  logic [tdpl_pkg::ValW-1:0] pend_q, pend_d;
  logic                      out_vld_q, out_vld_d;
  logic [tdpl_pkg::ValW-1:0] out_val_q, out_val_d;
  logic                      out_res_q, out_res_d;
  logic                      out_last_q, out_last_d;
  logic                      out_take;

  assign out_take = out_vld_q && out_o.ready;
  assign adv_o    = !out_vld_q || out_o.ready;
  assign done_o   = out_take && out_last_q;

  always_comb begin
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_take ? 1'b0 : out_vld_q;
    out_val_d  = out_val_q;
    out_res_d  = out_res_q;
    out_last_d = out_last_q;
    if (adv_o && tok_i.vld) begin
      if (tok_i.fin) begin
        out_vld_d  = 1'b1;
        out_val_d  = pend_vld_q ? pend_q : '0;
        out_res_d  = pend_vld_q;
        out_last_d = 1'b1;
        pend_vld_d = 1'b0;
      end else if (!tok_i.comp) begin
        if (pend_vld_q) begin
          out_vld_d  = 1'b1;
          out_val_d  = pend_q;
          out_res_d  = 1'b1;
          out_last_d = 1'b0;
        end
        pend_vld_d = 1'b1;
        pend_d     = tok_i.num;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_val_q  <= out_val_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.prime_value = out_val_q;
  assign out_o.valid_res   = out_res_q;
  assign out_o.last        = out_last_q;

endmodule

[sim/prime_list_checker.sv]
`timescale 1ns / 1ps
// Watches both channels of the prime lister, predicts the primes for each
// accepted limit by trial division and compares every result item in order.
// Depends on tdpl_pkg.
module prime_list_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [tdpl_pkg::ValW-1:0] limit_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [tdpl_pkg::ValW-1:0] prime_value_i,
  input  logic                      valid_res_i,
  input  logic                      last_i,
  output int unsigned               mismatches_o,
  output int unsigned               outstanding_o
);

  localparam int unsigned MaxPrimes = 64;

  typedef struct packed {
    logic [tdpl_pkg::ValW-1:0] value;
    logic                      present;
    logic                      closes;
  } prime_res_t;

  prime_res_t primes_due[$];

  function automatic bit is_prime(input int unsigned n);
    int unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d < n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic queue_primes_upto(input logic [tdpl_pkg::ValW-1:0] lim);
    int unsigned ceiling;
    int unsigned total;
    int unsigned idx;
    int unsigned n;
    prime_res_t  res;
    ceiling = (lim > tdpl_pkg::LimitMax) ? 32'(tdpl_pkg::LimitMax) : 32'(lim);
    total = 0;
    for (n = 2; n <= ceiling; n++) begin
      if (is_prime(n) && total < MaxPrimes) total++;
    end
    if (total == 0) begin
      res.value   = '0;
      res.present = 1'b0;
      res.closes  = 1'b1;
      primes_due.push_back(res);
    end else begin
      idx = 0;
      for (n = 2; n <= ceiling && idx < total; n++) begin
        if (is_prime(n)) begin
          res.value   = n[tdpl_pkg::ValW-1:0];
          res.present = 1'b1;
          res.closes  = (idx == total - 1);
          primes_due.push_back(res);
          idx++;
        end
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input prime_res_t want);
    if (mismatches_o < 10) begin
      $display("%t mismatch (%s): expected value %0d valid %0b last %0b,",
               $realtime, what, want.value, want.present, want.closes);
      $display("    got value %0d valid %0b last %0b",
               prime_value_i, valid_res_i, last_i);
    end
    mismatches_o = mismatches_o + 1;
  endtask

  always @(posedge clk_i) begin
    prime_res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) queue_primes_upto(limit_i);
      if (out_valid_i && out_ready_i) begin
        if (primes_due.size() == 0) begin
          want = '0;
          flag_mismatch("no item expected", want);
        end else begin
          want = primes_due.pop_front();
          if (prime_value_i !== want.value || valid_res_i !== want.present ||
              last_i !== want.closes) begin
            flag_mismatch("field", want);
          end
        end
      end
      outstanding_o = primes_due.size();
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Top of the prime lister regression: drives limits in random bursts, stalls
// the result side, and gives the verdict from the checker's counts.
// Depends on tdpl_pkg, the channel interfaces, the block and prime_list_checker.
module testbench;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned RandomItems = 82;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned HoldCycles  = 600;

  logic clk_i;
  logic rst_ni;

  tdpl_in_if  limit_ch ();
  tdpl_out_if prime_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycles;
  int unsigned items_taken;
  int unsigned burst_left;
  bit          holding;

  trial_division_prime_lister dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (limit_ch),
    .out_o  (prime_ch)
  );

  prime_list_checker prime_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (limit_ch.valid),
    .in_ready_i    (limit_ch.ready),
    .limit_i       (limit_ch.limit),
    .out_valid_i   (prime_ch.valid),
    .out_ready_i   (prime_ch.ready),
    .prime_value_i (prime_ch.prime_value),
    .valid_res_i   (prime_ch.valid_res),
    .last_i        (prime_ch.last),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one limit; when the burst runs out, it may add a gap.
  task automatic offer_limit(input logic [tdpl_pkg::ValW-1:0] lim);
    int unsigned gap;
    limit_ch.valid <= 1'b1;
    limit_ch.limit <= lim;
    do @(posedge clk_i); while (!limit_ch.ready);
    items_taken++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !holding) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        limit_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [tdpl_pkg::ValW-1:0] pick_limit();
    case ($urandom_range(0, 9)) inside
      [0:4]:   return 9'($urandom_range(0, 40));
      [5:6]:   return 9'($urandom_range(0, 311));
      7:       return 9'($urandom_range(300, 511));
      8:       return 9'($urandom_range(0, 511));
      default: return 9'($urandom_range(0, 3));
    endcase
  endfunction

  // Result side: segments of free flow, random stalls and heavy stalls, with
  // one long hold-off once the input is well under way.
  initial begin
    int unsigned seg;
    int unsigned mode;
    bit          held;
    held = 1'b0;
    prime_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && items_taken >= 30) begin
        held = 1'b1;
        holding = 1'b1;
        prime_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holding = 1'b0;
      end
      seg  = $urandom_range(10, 150);
      mode = $urandom_range(0, 2);
      repeat (seg) begin
        case (mode)
          0:       prime_ch.ready <= 1'b1;
          1:       prime_ch.ready <= 1'($urandom_range(0, 1));
          default: prime_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [tdpl_pkg::ValW-1:0] directed[$];
    int unsigned               i;
    items_taken = 0;
    burst_left  = $urandom_range(1, 8);
    rst_ni      = 1'b0;
    limit_ch.valid <= 1'b0;
    limit_ch.limit <= '0;
    directed = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd13, 9'd17, 9'd18, 9'd100,
                 9'd255, 9'd256, 9'd310, 9'd311, 9'd312, 9'd511, 9'd170, 9'd85};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[j]) offer_limit(directed[j]);
    for (i = 0; i < RandomItems; i++) offer_limit(pick_limit());
    limit_ch.valid <= 1'b0;

    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
